/* rtl/cau_pkg.sv */
// Package: widths, opcodes and status codes for the complex arithmetic unit.
package cau_pkg;

    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int OpWidth   = 2;
    localparam int StWidth   = 2;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [StWidth-1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

endpackage

/* rtl/cau_div_stage.sv */
// One restoring-division step per register stage for two quotients in parallel.
module cau_div_stage #(
    parameter int NW  = 128,
    parameter int DW  = 130,
    parameter int TW  = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_nre,
    input  logic [NW-1:0] i_nim,
    input  logic [DW-1:0] i_rre,
    input  logic [DW-1:0] i_rim,
    input  logic [DW-1:0] i_d,
    input  logic [TW-1:0] i_tag,
    output logic [NW-1:0] o_nre,
    output logic [NW-1:0] o_nim,
    output logic [DW-1:0] o_rre,
    output logic [DW-1:0] o_rim,
    output logic [DW-1:0] o_d,
    output logic [TW-1:0] o_tag
);
    logic [DW-1:0] n_tre, n_tim, n_sre, n_sim;
    logic [NW-1:0] r_nre, r_nim;
    logic [DW-1:0] r_rre, r_rim, r_d;
    logic [TW-1:0] r_tag;

    always_comb begin
        n_tre = {i_rre[DW-2:0], i_nre[NW-1]};
        n_tim = {i_rim[DW-2:0], i_nim[NW-1]};
        n_sre = n_tre - i_d;
        n_sim = n_tim - i_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nre <= {i_nre[NW-2:0], ~n_sre[DW-1]};
            r_nim <= {i_nim[NW-2:0], ~n_sim[DW-1]};
            r_rre <= n_sre[DW-1] ? n_tre : n_sre;
            r_rim <= n_sim[DW-1] ? n_tim : n_sim;
            r_d   <= i_d;
            r_tag <= i_tag;
        end
    end

    assign o_nre = r_nre;
    assign o_nim = r_nim;
    assign o_rre = r_rre;
    assign o_rim = r_rim;
    assign o_d   = r_d;
    assign o_tag = r_tag;
endmodule

/* rtl/complex_arith_unit.sv */
// Top level: pipelined complex add, subtract, multiply and divide on fixed point.
//
// Streaming unit. One beat on the slave side carries op and operands a and b;
// one beat on the master side carries the result parts and a status code.
// Pipeline: three stages for products, sums and magnitudes, then one quotient
// bit per stage of the restoring divider (NW = 2*DATA_WIDTH + FRAC_BITS + 1
// quotient bits), one stage for saturation. All opcodes take the same path, so
// results leave in order.
// Throughput is one beat per cycle while the receiver takes results. The whole
// pipeline advances when the output register is empty or being taken; when the
// receiver stalls every stage holds and s_axis_tready falls only if the output
// register is full. Nothing is lost or repeated.
// Reset clears every valid bit; payload registers are not reset.
// Status: 0 ok, 1 divide by zero (zero parts), 2 saturated.
module complex_arith_unit #(
    parameter int DATA_WIDTH = cau_pkg::DataWidth,
    parameter int FRAC_BITS  = cau_pkg::FracBits
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // op, a_re, a_im, b_re, b_im from bit 0 up, zero padded to bytes
    input  logic [((4*DATA_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // res_re, res_im, status from bit 0 up, zero padded to bytes
    output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);
    localparam int W   = DATA_WIDTH;
    localparam int IW  = ((4*W+2+7)/8)*8;
    localparam int OW  = ((2*W+2+7)/8)*8;
    localparam int PW  = 2*W + 2;          // signed sum of two products
    localparam int NW  = 2*W + 1 + FRAC_BITS; // magnitude numerator width
    localparam int DW  = 2*W + 2;          // divisor / remainder width
    localparam int TW  = 4 + 2*W;          // tag: op, divz, signs, add-path results
    localparam int SW  = W + 1;

    logic en;
    logic r_ov;
    logic [OW-1:0] r_out;
    assign en = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: products, plus operand sums or differences for add and subtract
    logic r_v1;
    logic [1:0] r_op1;
    logic signed [2*W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    logic signed [SW-1:0] r_sr1, r_si1;
    logic signed [W-1:0] n_ar, n_ai, n_br, n_bi;
    logic [1:0] n_op;
    always_comb begin
        n_op = s_axis_tdata[1:0];
        n_ar = s_axis_tdata[2 +: W];
        n_ai = s_axis_tdata[2+W +: W];
        n_br = s_axis_tdata[2+2*W +: W];
        n_bi = s_axis_tdata[2+3*W +: W];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1  <= n_op;
            r_p_rr <= n_ar * n_br;
            r_p_ii <= n_ai * n_bi;
            r_p_ri <= n_ar * n_bi;
            r_p_ir <= n_ai * n_br;
            r_p_bb <= n_br * n_br;
            r_p_cc <= n_bi * n_bi;
            if (n_op == cau_pkg::OP_SUB) begin
                r_sr1 <= SW'(n_ar) - SW'(n_br);
                r_si1 <= SW'(n_ai) - SW'(n_bi);
            end else begin
                r_sr1 <= SW'(n_ar) + SW'(n_br);
                r_si1 <= SW'(n_ai) + SW'(n_bi);
            end
        end
    end

    // stage 2: sums of products
    logic r_v2;
    logic [1:0] r_op2;
    logic signed [PW-1:0] r_re2, r_im2;
    logic [DW-1:0] r_d2;
    logic signed [SW-1:0] r_sr2, r_si2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op2 <= r_op1;
            r_sr2 <= r_sr1;
            r_si2 <= r_si1;
            r_d2  <= DW'($unsigned(r_p_bb)) + DW'($unsigned(r_p_cc));
            if (r_op1 == cau_pkg::OP_MUL) begin
                r_re2 <= PW'(r_p_rr) - PW'(r_p_ii);
                r_im2 <= PW'(r_p_ri) + PW'(r_p_ir);
            end else begin
                r_re2 <= PW'(r_p_rr) + PW'(r_p_ii);
                r_im2 <= PW'(r_p_ir) - PW'(r_p_ri);
            end
        end
    end

    // stage 3: magnitudes and signs, numerator scaling
    logic r_v3;
    logic [TW-1:0] r_tag3;
    logic [NW-1:0] r_nre3, r_nim3;
    logic [DW-1:0] r_d3;
    logic [PW-1:0] n_mre, n_mim;
    logic n_isdiv, n_divz;
    always_comb begin
        n_mre = r_re2[PW-1] ? PW'(-r_re2) : PW'(r_re2);
        n_mim = r_im2[PW-1] ? PW'(-r_im2) : PW'(r_im2);
        n_isdiv = r_op2 == cau_pkg::OP_DIV;
        n_divz  = n_isdiv && (r_d2 == '0);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag3 <= {r_op2, n_divz, r_re2[PW-1] ^ r_im2[PW-1] ^ r_im2[PW-1],
                       r_sr2[W-1:0], r_si2[W-1:0]};
            if (n_isdiv) begin
                r_nre3 <= NW'(n_mre) << FRAC_BITS;
                r_nim3 <= NW'(n_mim) << FRAC_BITS;
                r_d3   <= n_divz ? DW'(1) : r_d2;
            end else begin
                r_nre3 <= NW'(n_mre);
                r_nim3 <= NW'(n_mim);
                r_d3   <= DW'(1) << FRAC_BITS;
            end
        end
    end
    // signs travel alongside; keep them in a small side pipeline
    logic r_sgr3, r_sgi3;
    logic signed [SW-1:0] r_sr3, r_si3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sgr3 <= r_re2[PW-1];
            r_sgi3 <= r_im2[PW-1];
            r_sr3  <= r_sr2;
            r_si3  <= r_si2;
        end
    end

    // divider: NW steps, one bit each
    logic [NW-1:0] w_nre [0:NW];
    logic [NW-1:0] w_nim [0:NW];
    logic [DW-1:0] w_rre [0:NW];
    logic [DW-1:0] w_rim [0:NW];
    logic [DW-1:0] w_d   [0:NW];
    logic [TW+2*SW+1:0] w_tag [0:NW];
    logic [NW:1] r_vd;
    logic [NW:0] w_vd;

    assign w_nre[0] = r_nre3;
    assign w_nim[0] = r_nim3;
    assign w_rre[0] = '0;
    assign w_rim[0] = '0;
    assign w_d[0]   = r_d3;
    assign w_tag[0] = {r_tag3, r_sgr3, r_sgi3, r_sr3, r_si3};
    assign w_vd     = {r_vd, r_v3};

    for (genvar g = 0; g < NW; g++) begin : g_div
        cau_div_stage #(.NW(NW), .DW(DW), .TW(TW+2*SW+2)) u_stage (
            .i_clk (i_clk),
            .i_en  (en),
            .i_nre (w_nre[g]),
            .i_nim (w_nim[g]),
            .i_rre (w_rre[g]),
            .i_rim (w_rim[g]),
            .i_d   (w_d[g]),
            .i_tag (w_tag[g]),
            .o_nre (w_nre[g+1]),
            .o_nim (w_nim[g+1]),
            .o_rre (w_rre[g+1]),
            .o_rim (w_rim[g+1]),
            .o_d   (w_d[g+1]),
            .o_tag (w_tag[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[g+1] <= 1'b0;
            end else if (en) begin
                r_vd[g+1] <= w_vd[g];
            end
        end
    end

    // final: sign, saturation, output register
    logic [TW+2*SW+1:0] n_t;
    logic [1:0] n_fop;
    logic n_fdz, n_sgr, n_sgi, n_ovf;
    logic signed [SW-1:0] n_fsr, n_fsi;
    logic [NW-1:0] n_qre, n_qim;
    logic [W-1:0] n_rre, n_rim;
    logic [1:0] n_st;
    logic [W-1:0] n_max, n_min;

    function automatic logic [W:0] sat_mag(input logic [NW-1:0] q, input logic neg);
        logic [W-1:0] mx;
        logic [W-1:0] v;
        logic o;
        begin
            mx = {1'b0, {(W-1){1'b1}}};
            o  = 1'b0;
            if (!neg) begin
                if (q > NW'(mx)) begin
                    o = 1'b1;
                    v = mx;
                end else begin
                    v = q[W-1:0];
                end
            end else begin
                if (q > NW'(mx) + NW'(1)) begin
                    o = 1'b1;
                    v = ~mx;
                end else begin
                    v = W'(-q[W-1:0]);
                end
            end
            sat_mag = {o, v};
        end
    endfunction

    logic [W:0] n_a, n_b;
    always_comb begin
        n_t   = w_tag[NW];
        n_fop = n_t[TW+2*SW+1 -: 2];
        n_fdz = n_t[TW+2*SW-1];
        n_sgr = n_t[2*SW+1];
        n_sgi = n_t[2*SW];
        n_fsr = n_t[2*SW-1 -: SW];
        n_fsi = n_t[SW-1:0];
        n_qre = w_nre[NW];
        n_qim = w_nim[NW];
        n_max = {1'b0, {(W-1){1'b1}}};
        n_min = ~n_max;
        n_a = sat_mag(n_qre, n_sgr);
        n_b = sat_mag(n_qim, n_sgi);
        n_ovf = 1'b0;
        n_rre = '0;
        n_rim = '0;
        case (n_fop)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                n_rre = n_fsr[W-1:0];
                n_rim = n_fsi[W-1:0];
                if (n_fsr[SW-1] != n_fsr[W-1]) begin
                    n_rre = n_fsr[SW-1] ? n_min : n_max;
                    n_ovf = 1'b1;
                end
                if (n_fsi[SW-1] != n_fsi[W-1]) begin
                    n_rim = n_fsi[SW-1] ? n_min : n_max;
                    n_ovf = 1'b1;
                end
            end
            default: begin
                n_rre = n_a[W-1:0];
                n_rim = n_b[W-1:0];
                n_ovf = n_a[W] | n_b[W];
            end
        endcase
        if (n_fdz) begin
            n_st = cau_pkg::ST_DIVZ;
            n_rre = '0;
            n_rim = '0;
        end else if (n_ovf) begin
            n_st = cau_pkg::ST_OVF;
        end else begin
            n_st = cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_vd[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= OW'({n_st, n_rim, n_rre});
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    logic n_unused;
    assign n_unused = ^{s_axis_tdata[IW-1:4*W+2], w_rre[NW], w_rim[NW], w_d[NW],
                        n_t[TW+2*SW-2:2*SW+2]};
endmodule
